FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL: clocked properties on clk, muted in
// reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Geometry, address split and transaction types of the direct-mapped
// write-back cache.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Cache and backing store geometry (powers of two)
  localparam int NUM_LINES      = 64;
  localparam int WORDS_PER_LINE = 4;
  localparam int MEM_WORDS      = 1024;
  localparam int WORD_W         = 32;
  localparam int ADDR_W         = 12;

  // Byte address split: byte select, word offset, line index, tag
  localparam int BYTE_W = 2;
  localparam int OFF_W  = $clog2(WORDS_PER_LINE);
  localparam int IDX_W  = $clog2(NUM_LINES);
  localparam int TAG_W  = ADDR_W - BYTE_W - OFF_W - IDX_W;
  localparam int OFF_LO = BYTE_W;
  localparam int IDX_LO = BYTE_W + OFF_W;
  localparam int TAG_LO = IDX_LO + IDX_W;

  // Backing store is held one line per row
  localparam int MEM_ROWS = MEM_WORDS / WORDS_PER_LINE;
  localparam int ROW_W    = $clog2(MEM_ROWS);
  localparam int LINE_W   = WORDS_PER_LINE * WORD_W;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic [WORDS_PER_LINE-1:0][WORD_W-1:0] line_words_t;

  // One cache entry: tag, dirty flag and the line's words
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             dirty;
    line_words_t      words;
  } cache_entry_t;

  localparam int ENTRY_W = $bits(cache_entry_t);

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] byte_address;
    logic [WORD_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] read_data;
    logic              evicted_dirty;
  } rsp_t;

endpackage

FILE: rtl/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/direct_mapped_writeback_cache_core.sv
// The accepting cycle registers the request and starts the registered read of the
//   cache RAM and backing RAM; ST_LOOKUP then does the lookup and write-back, which
//   lands before the next read. No new access is taken until the lookup completes and
//   registers the result. A result held by out_ready stalls the lookup.
// A miss with write-back and fill takes no extra states: whole lines move.
// Reset: line and backing-row valid flags clear together; no clearing pass.
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_core
// Direct-mapped, write-back, write-allocate cache in front of a line-wide
// backing store, both held in synchronous RAMs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module direct_mapped_writeback_cache_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dmc_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dmc_pkg::rsp_t out_data
);

  import dmc_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  logic state, state_next;
  req_t req;

  logic [NUM_LINES-1:0] line_valid;
  logic [MEM_ROWS-1:0]  row_valid;

  logic [ADDR_W-1:0] rd_addr;
  logic [OFF_W-1:0]  off;
  logic [IDX_W-1:0]  idx;
  logic [TAG_W-1:0]  tag;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  evict_row;

  cache_entry_t entry_rd, entry_wr;
  line_words_t  back_rd;
  line_words_t  fill_words, base_words, new_words;

  logic hit, evict, done, in_accept;
  rsp_t rsp;

  // Split the held request address
  assign off       = req.byte_address[OFF_LO +: OFF_W];
  assign idx       = req.byte_address[IDX_LO +: IDX_W];
  assign tag       = req.byte_address[TAG_LO +: TAG_W];
  assign row       = req.byte_address[IDX_LO +: ROW_W];
  assign evict_row = {entry_rd.tag, idx};

  // Read from the incoming address when idle, hold the request's otherwise
  assign rd_addr = (state == ST_IDLE) ? in_data.byte_address : req.byte_address;

  assign in_ready  = (state == ST_IDLE) && !rst;
  assign in_accept = in_valid && in_ready;
  assign done      = (state == ST_LOOKUP) && (!out_valid || out_ready);

  // Cache line store: tag, dirty and words per line
  dmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LINES)
  ) u_cache_ram (
    .clk   (clk),
    .we    (done),
    .waddr (idx),
    .wdata (entry_wr),
    .raddr (rd_addr[IDX_LO +: IDX_W]),
    .rdata (entry_rd)
  );

  // Backing store, one line per row
  dmc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MEM_ROWS)
  ) u_back_ram (
    .clk   (clk),
    .we    (done && evict),
    .waddr (evict_row),
    .wdata (entry_rd.words),
    .raddr (rd_addr[IDX_LO +: ROW_W]),
    .rdata (back_rd)
  );

  // Look up, merge the write and build the result
  always_comb begin
    hit        = line_valid[idx] && (entry_rd.tag == tag);
    evict      = !hit && line_valid[idx] && entry_rd.dirty;
    fill_words = row_valid[row] ? back_rd : '0;
    base_words = hit ? entry_rd.words : fill_words;
    new_words  = base_words;
    if (req.op == OP_WRITE) begin
      new_words[off] = req.write_data;
    end
    entry_wr.tag   = tag;
    entry_wr.dirty = (hit && entry_rd.dirty) || (req.op == OP_WRITE);
    entry_wr.words = new_words;
    rsp.hit           = hit;
    rsp.read_data     = (req.op == OP_WRITE) ? '0 : base_words[off];
    rsp.evicted_dirty = evict;
  end

  // Advance the access sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      line_valid <= '0;
      row_valid  <= '0;
    end else begin
      state     <= state_next;
      out_valid <= done || (out_valid && !out_ready);
      if (done) begin
        line_valid[idx] <= 1'b1;
        if (evict) begin
          row_valid[evict_row] <= 1'b1;
        end
      end
    end
  end

  // Hold the request and the result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req <= in_data;
    end
    if (done) begin
      out_data <= rsp;
    end
  end

  `ASSERT_CLK(a_evict_miss, !(out_valid && out_data.evicted_dirty && out_data.hit), "evict on hit")
  `ASSERT_NEXT(a_write_zero, done && (req.op == OP_WRITE), out_data.read_data == '0, "write data")
  `ASSERT_NEXT(a_line_valid_after, done, line_valid[idx], "line not valid after access")
  `ASSERT_NEXT(a_result_after_done, done, out_valid, "completed access left no result")

endmodule

FILE: tb/tb_direct_mapped_writeback_cache_core.sv
// ----------------------------------------------------------------------------
// tb_direct_mapped_writeback_cache_core
// Self-checking bench for the direct-mapped write-back cache. A cycle-free
// copy of the cache and backing store predicts hit, read word and write-back
// for every accepted access. Each returned transaction is compared against
// the oldest prediction, under random gaps, output stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_direct_mapped_writeback_cache_core;
  import dmc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  req_t  in_data;
  logic  out_valid;
  logic  out_ready;
  rsp_t  out_data;

  // Shadow cache and backing store
  logic              line_present  [NUM_LINES];
  logic              line_modified [NUM_LINES];
  logic [TAG_W-1:0]  line_tag_copy [NUM_LINES];
  logic [WORD_W-1:0] cached_words  [NUM_LINES][WORDS_PER_LINE];
  logic [WORD_W-1:0] store_words   [MEM_WORDS];

  rsp_t pending_access_results[$];
  int   mismatch_count;
  int   idle_cycles;
  logic gaps_on;
  logic rx_stalls_on;
  int   hold_off_len;
  int   hold_off_serial;

  direct_mapped_writeback_cache_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Predict one access and update the shadow state
  function automatic rsp_t cache_access_outcome(input req_t item);
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tg;
    int               base;
    rsp_t             res;
    off = item.byte_address[OFF_LO +: OFF_W];
    idx = item.byte_address[IDX_LO +: IDX_W];
    tg  = item.byte_address[TAG_LO +: TAG_W];
    res = '0;
    res.hit = line_present[idx] && (line_tag_copy[idx] == tg);
    if (!res.hit) begin
      // write back a dirty victim, then fill
      if (line_present[idx] && line_modified[idx]) begin
        base = (int'({line_tag_copy[idx], idx}) * WORDS_PER_LINE) % MEM_WORDS;
        for (int w = 0; w < WORDS_PER_LINE; w++)
          store_words[(base + w) % MEM_WORDS] = cached_words[idx][w];
        res.evicted_dirty = 1'b1;
      end
      base = (int'({tg, idx}) * WORDS_PER_LINE) % MEM_WORDS;
      for (int w = 0; w < WORDS_PER_LINE; w++)
        cached_words[idx][w] = store_words[(base + w) % MEM_WORDS];
      line_present[idx]  = 1'b1;
      line_tag_copy[idx] = tg;
      line_modified[idx] = 1'b0;
    end
    if (item.op == OP_WRITE) begin
      cached_words[idx][off] = item.write_data;
      line_modified[idx]     = 1'b1;
    end else begin
      res.read_data = cached_words[idx][off];
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] make_address(input int tg, input int idx,
                                                      input int off, input int bsel);
    logic [ADDR_W-1:0] a;
    a = '0;
    a[TAG_LO +: TAG_W]   = tg[TAG_W-1:0];
    a[IDX_LO +: IDX_W]   = idx[IDX_W-1:0];
    a[OFF_LO +: OFF_W]   = off[OFF_W-1:0];
    a[0 +: BYTE_W]       = bsel[BYTE_W-1:0];
    return a;
  endfunction

  // Offer one transaction from a falling edge; leave valid high on return
  task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] data);
    int   gap;
    int   r;
    req_t item;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95)
        gap = $urandom_range(8, 30);
      else if (r >= 70)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.op           = op;
    item.byte_address = addr;
    item.write_data   = data;
    in_data  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_access_results = {pending_access_results, cache_access_outcome(item)};
    @(negedge clk);
  endtask

  // Extremes of every field, hits, misses and both kinds of eviction
  task automatic test_directed_cases();
    gaps_on      = 1'b0;
    rx_stalls_on = 1'b0;
    send_access(OP_READ,  12'h000, 32'h0000_0000);  // miss on invalid line
    send_access(OP_WRITE, 12'h004, 32'hFFFF_FFFF);  // write hit
    send_access(OP_READ,  12'h007, 32'hFFFF_FFFF);  // byte bits ignored
    send_access(OP_WRITE, 12'h400, 32'h1234_5678);  // write miss, dirty victim
    send_access(OP_READ,  12'h004, 32'h0000_0000);  // dirty victim, refetch
    send_access(OP_READ,  12'h800, 32'h0000_0000);  // miss on clean line
    send_access(OP_READ,  12'h400, 32'h0000_0000);  // clean miss, written data
    send_access(OP_WRITE, 12'hFFF, 32'h0000_0000);  // top address
    send_access(OP_READ,  12'hFFC, 32'hFFFF_FFFF);
    send_access(OP_WRITE, 12'hFFE, 32'hA5A5_A5A5);
    send_access(OP_READ,  12'h3FF, 32'h0000_0000);  // evict top line
    send_access(OP_READ,  12'hFFD, 32'h0000_0000);  // clean miss, reload
    send_access(OP_WRITE, 12'h0F0, 32'h8000_0000);
    send_access(OP_READ,  12'h0F0, 32'h0000_0000);
    send_access(OP_WRITE, 12'hAA9, 32'h5A5A_5A5A);
    send_access(OP_WRITE, 12'h555, 32'h0000_0001);
    send_access(OP_READ,  12'hAA8, 32'h0000_0000);
    send_access(OP_READ,  12'h554, 32'h0000_0000);
  endtask

  // Conflict-heavy random traffic: most accesses land on a few hot lines
  task automatic test_random_accesses(input int count, input logic with_gaps);
    int               hot [4];
    int               r;
    logic             op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    gaps_on      = with_gaps;
    rx_stalls_on = with_gaps;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0)
        foreach (hot[k]) hot[k] = $urandom_range(0, NUM_LINES - 1);
      op = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
      if ($urandom_range(0, 9) < 7)
        addr = make_address($urandom_range(0, (1 << TAG_W) - 1), hot[$urandom_range(0, 3)],
                            $urandom_range(0, WORDS_PER_LINE - 1),
                            $urandom_range(0, (1 << BYTE_W) - 1));
      else
        addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
      r = $urandom_range(0, 9);
      if (r == 0)
        data = '0;
      else if (r == 1)
        data = '1;
      else
        data = $urandom;
      send_access(op, addr, data);
    end
  endtask

  // Hold the output off for a long stretch while offering back-to-back
  task automatic test_output_backpressure();
    gaps_on         = 1'b0;
    rx_stalls_on    = 1'b0;
    hold_off_len    = 80;
    hold_off_serial = hold_off_serial + 1;
    for (int i = 0; i < 30; i++)
      send_access((i % 3 == 0) ? OP_WRITE : OP_READ,
                  make_address(i % 4, i % 2, i % WORDS_PER_LINE, 0), $urandom);
  endtask

  // Drive output ready: random stalls, or a requested hold-off
  initial begin
    int stall_left;
    int r;
    int seen_serial;
    out_ready   = 1'b0;
    stall_left  = 0;
    seen_serial = 0;
    forever begin
      @(negedge clk);
      if (hold_off_serial != seen_serial) begin
        stall_left  = hold_off_len;
        seen_serial = hold_off_serial;
      end
      if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready = 1'b1;
        if (rx_stalls_on) begin
          r = $urandom_range(0, 99);
          if (r < 15)
            stall_left = $urandom_range(1, 3);
          else if (r < 17)
            stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Compare each returned transaction with the oldest prediction
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && out_valid && out_ready) begin
      if (pending_access_results.size() == 0) begin
        $display("%0t: unexpected result hit=%0b read_data=%h evicted_dirty=%0b",
                 $time, out_data.hit, out_data.read_data, out_data.evicted_dirty);
        mismatch_count++;
      end else begin
        exp_rsp = pending_access_results.pop_front();
        if (out_data.hit !== exp_rsp.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_rsp.hit, out_data.hit);
          mismatch_count++;
        end
        if (out_data.read_data !== exp_rsp.read_data) begin
          $display("%0t: read_data expected %h actual %h",
                   $time, exp_rsp.read_data, out_data.read_data);
          mismatch_count++;
        end
        if (out_data.evicted_dirty !== exp_rsp.evicted_dirty) begin
          $display("%0t: evicted_dirty expected %0b actual %0b",
                   $time, exp_rsp.evicted_dirty, out_data.evicted_dirty);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    in_data         = '0;
    gaps_on         = 1'b0;
    rx_stalls_on    = 1'b0;
    hold_off_len    = 0;
    hold_off_serial = 0;
    foreach (line_present[i]) begin
      line_present[i]  = 1'b0;
      line_modified[i] = 1'b0;
      line_tag_copy[i] = '0;
      foreach (cached_words[i][w]) cached_words[i][w] = '0;
    end
    foreach (store_words[i]) store_words[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_accesses(452, 1'b1);
    test_output_backpressure();
    test_random_accesses(60, 1'b0);
    test_random_accesses(40, 1'b1);

    // Drain, then allow the pipeline to settle
    in_valid     = 1'b0;
    rx_stalls_on = 1'b0;
    while (pending_access_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
